@@ sv/brbcs_pkg.sv @@
// Package for the byte ring buffer with checksum unit.
// Holds the storage geometry, field widths, command codes and shared types.
// No dependencies; brbcs_sum_unit and the top level refer to it by scoped names.
package brbcs_pkg;

   // Ring storage geometry. Addressing wraps on PTR_W bits, so CAPACITY is a power of two.
   localparam int CAPACITY = 64;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Transaction field widths.
   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int STEP_W  = 7;
   localparam int START_W = 6;
   localparam int END_W   = 7;
   localparam int LEVEL_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE  = 3'd0,
      CMD_READ   = 3'd1,
      CMD_REWIND = 3'd2,
      CMD_SKIP   = 3'd3,
      CMD_CLEAR  = 3'd4,
      CMD_VERIFY = 3'd5,
      CMD_APPEND = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DRAIN
   } state_type;

   // Control of the checksum accumulator.
   typedef struct packed {
      logic init;
      logic add;
   } sum_ctrl_type;

endpackage

@@ sv/brbcs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module brbcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/brbcs_sum_unit.sv @@
// Running 8-bit wrapping checksum accumulator used while walking the stored bytes.
// Depends on brbcs_pkg for the byte width and the control struct.
module brbcs_sum_unit (
   input  logic                         clock,
   input  brbcs_pkg::sum_ctrl_type      ctrl,
   input  logic [brbcs_pkg::BYTE_W-1:0] data,
   output logic [brbcs_pkg::BYTE_W-1:0] acc,
   output logic [brbcs_pkg::BYTE_W-1:0] acc_plus
);

   logic [brbcs_pkg::BYTE_W-1:0] acc_ff;
   logic [brbcs_pkg::BYTE_W-1:0] acc_in;

   // The sum wraps naturally at the byte width.
   assign acc_plus = acc_ff + data;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.init) begin
         acc_in = '0;
      end else if (ctrl.add) begin
         acc_in = acc_plus;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

@@ sv/byte_ring_buffer_with_checksum_unit.sv @@
// Top level of the byte ring buffer with checksum unit.
// Depends on brbcs_pkg, brbcs_ram and brbcs_sum_unit.
//
// A circular byte FIFO of brbcs_pkg::CAPACITY bytes with a read position and a fill count.
// A transaction is taken at a rising edge where start is high and busy is low, and its single
// result appears on the rsp_ ports for exactly one cycle, marked by rsp_valid, in the cycle
// after the transaction (or after the walk ends for checksum commands). The receiver cannot
// stall: a result is simply presented for that one cycle. Write, read, rewind, skip and clear each
// stay in the idle state, so they can follow one another every cycle; busy stays low throughout.
// Verify and append-sum walk the stored bytes through the single read port of the byte
// memory, one byte per cycle, then wait in a drain state for the last read to return;
// busy stays high meanwhile, but stays low when verify finds the buffer empty or append-sum
// finds the range empty. After reset, busy stays high while the memory is swept to zero,
// one entry per cycle.
// Bytes past the fill count that a checksum range reaches read the stale store contents.
module byte_ring_buffer_with_checksum_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [brbcs_pkg::CMD_W-1:0]   req_cmd,
   input  logic [brbcs_pkg::BYTE_W-1:0]  req_wr_byte,
   input  logic [brbcs_pkg::STEP_W-1:0]  req_step_count,
   input  logic [brbcs_pkg::START_W-1:0] req_sum_start,
   input  logic [brbcs_pkg::END_W-1:0]   req_sum_end,
   output logic                          rsp_valid,
   output logic [brbcs_pkg::BYTE_W-1:0]  rsp_rd_byte,
   output logic [brbcs_pkg::LEVEL_W-1:0] rsp_fill_level,
   output logic                          rsp_applied,
   output logic                          rsp_sum_ok,
   output logic [brbcs_pkg::BYTE_W-1:0]  rsp_sum_value
);

   // Control state.
   brbcs_pkg::state_type         state_ff, state_in;
   logic [brbcs_pkg::PTR_W-1:0]  rp_ff, rp_in;
   logic [brbcs_pkg::CNT_W-1:0]  fill_ff, fill_in;
   logic [brbcs_pkg::PTR_W-1:0]  clr_ff, clr_in;
   logic [brbcs_pkg::CNT_W-1:0]  off_ff, off_in;
   logic [brbcs_pkg::CNT_W-1:0]  stop_ff, stop_in;
   logic                         verify_ff, verify_in;
   logic                         pend_ff, pend_in;

   // Result registers.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_rd_sel_ff, rsp_rd_sel_in;
   logic                         rsp_applied_ff, rsp_applied_in;
   logic                         rsp_sum_ok_ff, rsp_sum_ok_in;
   logic [brbcs_pkg::BYTE_W-1:0] rsp_sum_value_ff, rsp_sum_value_in;

   // Memory and accumulator connections.
   logic                         ram_we;
   logic [brbcs_pkg::PTR_W-1:0]  ram_waddr;
   logic [brbcs_pkg::BYTE_W-1:0] ram_wdata;
   logic                         ram_re;
   logic [brbcs_pkg::PTR_W-1:0]  ram_raddr;
   logic [brbcs_pkg::BYTE_W-1:0] ram_rdata;
   brbcs_pkg::sum_ctrl_type      sum_ctrl;
   logic [brbcs_pkg::BYTE_W-1:0] acc;
   logic [brbcs_pkg::BYTE_W-1:0] acc_plus;

   // Decoded helpers.
   logic                         accept;
   logic                         full;
   logic [brbcs_pkg::PTR_W-1:0]  tail_addr;
   logic [brbcs_pkg::CNT_W-1:0]  step;
   logic [brbcs_pkg::CNT_W:0]    grown;
   logic [brbcs_pkg::CNT_W-1:0]  app_start;
   logic [brbcs_pkg::CNT_W-1:0]  app_stop;
   logic [brbcs_pkg::CNT_W-1:0]  off_next;

   assign accept    = start && (state_ff == brbcs_pkg::ST_IDLE);
   assign busy      = (state_ff != brbcs_pkg::ST_IDLE);
   assign full      = (fill_ff == brbcs_pkg::CNT_W'(brbcs_pkg::CAPACITY));
   assign tail_addr = rp_ff + fill_ff[brbcs_pkg::PTR_W-1:0];
   assign step      = brbcs_pkg::CNT_W'(req_step_count);
   assign grown     = {1'b0, fill_ff} + {1'b0, step};
   assign app_start = brbcs_pkg::CNT_W'(req_sum_start);
   // The explicit end counts only when it lies above the start; otherwise sum up to the fill.
   assign app_stop  = (brbcs_pkg::CNT_W'(req_sum_end) > app_start)
                      ? brbcs_pkg::CNT_W'(req_sum_end) : fill_ff;
   assign off_next  = off_ff + 1'b1;

   brbcs_ram #(
      .WIDTH (brbcs_pkg::BYTE_W),
      .DEPTH (brbcs_pkg::CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   brbcs_sum_unit u_sum (
      .clock    (clock),
      .ctrl     (sum_ctrl),
      .data     (ram_rdata),
      .acc      (acc),
      .acc_plus (acc_plus)
   );

   // Next state, memory accesses and result values.
   always_comb begin
      state_in         = state_ff;
      rp_in            = rp_ff;
      fill_in          = fill_ff;
      clr_in           = clr_ff;
      off_in           = off_ff;
      stop_in          = stop_ff;
      verify_in        = verify_ff;
      pend_in          = (state_ff == brbcs_pkg::ST_WALK);
      rsp_valid_in     = 1'b0;
      rsp_rd_sel_in    = rsp_rd_sel_ff;
      rsp_applied_in   = rsp_applied_ff;
      rsp_sum_ok_in    = rsp_sum_ok_ff;
      rsp_sum_value_in = rsp_sum_value_ff;
      ram_we           = 1'b0;
      ram_waddr        = tail_addr;
      ram_wdata        = req_wr_byte;
      ram_re           = 1'b0;
      ram_raddr        = rp_ff;
      sum_ctrl.init    = 1'b0;
      sum_ctrl.add     = 1'b0;

      case (state_ff)
         brbcs_pkg::ST_CLEAR: begin
            // Sweep the store to zero after reset, one entry per cycle.
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == brbcs_pkg::PTR_W'(brbcs_pkg::CAPACITY - 1)) begin
               state_in = brbcs_pkg::ST_IDLE;
            end
         end

         brbcs_pkg::ST_IDLE: begin
            if (accept) begin
               // Most commands finish here; their result shows in the next cycle.
               rsp_valid_in     = 1'b1;
               rsp_rd_sel_in    = 1'b0;
               rsp_applied_in   = 1'b0;
               rsp_sum_ok_in    = 1'b0;
               rsp_sum_value_in = '0;
               case (brbcs_pkg::cmd_type'(req_cmd))
                  brbcs_pkg::CMD_WRITE: begin
                     if (!full) begin
                        ram_we         = 1'b1;
                        fill_in        = fill_ff + 1'b1;
                        rsp_applied_in = 1'b1;
                     end
                  end
                  brbcs_pkg::CMD_READ: begin
                     if (fill_ff != '0) begin
                        ram_re         = 1'b1;
                        rp_in          = rp_ff + 1'b1;
                        fill_in        = fill_ff - 1'b1;
                        rsp_rd_sel_in  = 1'b1;
                        rsp_applied_in = 1'b1;
                     end
                  end
                  brbcs_pkg::CMD_REWIND: begin
                     if (grown < (brbcs_pkg::CNT_W + 1)'(brbcs_pkg::CAPACITY)) begin
                        rp_in          = rp_ff - step[brbcs_pkg::PTR_W-1:0];
                        fill_in        = grown[brbcs_pkg::CNT_W-1:0];
                        rsp_applied_in = (step != '0);
                     end
                  end
                  brbcs_pkg::CMD_SKIP: begin
                     if (fill_ff > step) begin
                        rp_in          = rp_ff + step[brbcs_pkg::PTR_W-1:0];
                        fill_in        = fill_ff - step;
                        rsp_applied_in = (step != '0);
                     end
                  end
                  brbcs_pkg::CMD_CLEAR: begin
                     rp_in   = '0;
                     fill_in = '0;
                  end
                  brbcs_pkg::CMD_VERIFY: begin
                     // An empty buffer verifies as false at once.
                     if (fill_ff != '0) begin
                        rsp_valid_in  = 1'b0;
                        sum_ctrl.init = 1'b1;
                        off_in        = '0;
                        stop_in       = fill_ff;
                        verify_in     = 1'b1;
                        state_in      = brbcs_pkg::ST_WALK;
                     end
                  end
                  brbcs_pkg::CMD_APPEND: begin
                     if (app_start >= app_stop) begin
                        // Empty range: the sum is zero and is appended directly unless the buffer is full.
                        ram_wdata = '0;
                        if (!full) begin
                           ram_we  = 1'b1;
                           fill_in = fill_ff + 1'b1;
                        end
                     end else begin
                        rsp_valid_in  = 1'b0;
                        sum_ctrl.init = 1'b1;
                        off_in        = app_start;
                        stop_in       = app_stop;
                        verify_in     = 1'b0;
                        state_in      = brbcs_pkg::ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         brbcs_pkg::ST_WALK: begin
            // Issue one read per cycle; the previous cycle's byte is added as it returns.
            ram_re       = 1'b1;
            ram_raddr    = rp_ff + off_ff[brbcs_pkg::PTR_W-1:0];
            sum_ctrl.add = pend_ff;
            off_in       = off_next;
            if (off_next == stop_ff) begin
               state_in = brbcs_pkg::ST_DRAIN;
            end
         end

         brbcs_pkg::ST_DRAIN: begin
            // The last byte of the walk is on the read port now.
            rsp_valid_in   = 1'b1;
            rsp_rd_sel_in  = 1'b0;
            rsp_applied_in = 1'b0;
            state_in       = brbcs_pkg::ST_IDLE;
            if (verify_ff) begin
               rsp_sum_value_in = acc;
               rsp_sum_ok_in    = (acc == ram_rdata);
            end else begin
               rsp_sum_value_in = acc_plus;
               rsp_sum_ok_in    = 1'b0;
               ram_wdata        = acc_plus;
               if (!full) begin
                  ram_we  = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = brbcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= brbcs_pkg::ST_CLEAR;
         rp_ff         <= '0;
         fill_ff       <= '0;
         clr_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_rd_sel_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rp_ff         <= rp_in;
         fill_ff       <= fill_in;
         clr_ff        <= clr_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_rd_sel_ff <= rsp_rd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff           <= off_in;
      stop_ff          <= stop_in;
      verify_ff        <= verify_in;
      rsp_applied_ff   <= rsp_applied_in;
      rsp_sum_ok_ff    <= rsp_sum_ok_in;
      rsp_sum_value_ff <= rsp_sum_value_in;
   end

   // The read data register holds the byte of a read transaction during its result cycle.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rd_byte    = rsp_rd_sel_ff ? ram_rdata : '0;
   assign rsp_fill_level = brbcs_pkg::LEVEL_W'(fill_ff);
   assign rsp_applied    = rsp_applied_ff;
   assign rsp_sum_ok     = rsp_sum_ok_ff;
   assign rsp_sum_value  = rsp_sum_value_ff;

`ifndef SYNTHESIS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= brbcs_pkg::CNT_W'(brbcs_pkg::CAPACITY))
      else $error("fill count exceeds capacity");

   a_walk_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brbcs_pkg::ST_WALK) |-> !ram_we)
      else $error("memory written during a checksum walk");

   a_walk_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brbcs_pkg::ST_WALK) |=> !rsp_valid)
      else $error("result issued in the middle of a walk");

   a_drain_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brbcs_pkg::ST_DRAIN) |=> (rsp_valid && !busy))
      else $error("walk did not end with a result");

   a_simple_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd != brbcs_pkg::CMD_VERIFY && req_cmd != brbcs_pkg::CMD_APPEND)
      |=> rsp_valid)
      else $error("single-cycle transaction gave no result");
`endif

endmodule
